@@ hw/rtl/stc_pkg.sv @@
// Shared types, widths and arithmetic helpers for the sphere-triangle contact pipeline.
// Depends on nothing; used by stc_divider and sphere_triangle_contact_top.
package stc_pkg;

	localparam int CB   = 21;
	localparam int NF   = CB - 2;
	localparam int FW   = 3 * CB;
	localparam int DW   = CB + 1;
	localparam int AW   = DW + CB + 2;
	localparam int QW   = AW - NF + 1;
	localparam int PW   = QW + CB;
	localparam int PRW  = PW - NF + 1;
	localparam int XW   = 2 * DW + 1;
	localparam int SW   = XW + CB + 2;
	localparam int NW   = 2 * DW + 2;
	localparam int EW   = 2 * DW;
	localparam int TB   = 32;
	localparam int TW   = TB + 1 + DW;
	localparam int RTW  = TW - TB + 1;
	localparam int RADW = CB - 1;
	localparam int OW   = 2 * CB + 2;

	typedef logic [2:0] cls_t;

	localparam cls_t CLS_NONE     = 3'd0;
	localparam cls_t CLS_INTERIOR = 3'd1;
	localparam cls_t CLS_EDGE_AB  = 3'd2;
	localparam cls_t CLS_EDGE_BC  = 3'd3;
	localparam cls_t CLS_EDGE_CA  = 3'd4;
	localparam cls_t CLS_CORNER_A = 3'd5;
	localparam cls_t CLS_CORNER_B = 3'd6;
	localparam cls_t CLS_CORNER_C = 3'd7;

	typedef enum logic [1:0] {
		SEG_FIRST,
		SEG_MID,
		SEG_SECOND
	} seg_t;

	typedef struct packed {
		logic [2:0][CB-1:0]      c;
		logic [2:0][2:0][CB-1:0] v;
		logic [2:0][CB-1:0]      n;
		logic [RADW-1:0]         rad;
	} base_t;

	typedef struct packed {
		base_t              base;
		logic [2:0][CB-1:0] proj;
		logic [2:0]         on;
		logic [2:0]         ed;
		logic               enclosed;
	} side_t;

	function automatic logic [1:0] next_edge(input logic [1:0] i);
		return (i == 2'd2) ? 2'd0 : i + 2'd1;
	endfunction

	function automatic logic signed [CB-1:0] sat_coord(input logic signed [63:0] v);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = (64'sd1 <<< (CB - 1)) - 64'sd1;
		lo = -hi - 64'sd1;
		if (v > hi)
			return hi[CB-1:0];
		if (v < lo)
			return lo[CB-1:0];
		return v[CB-1:0];
	endfunction

	function automatic logic signed [QW-1:0] rnd_plane(input logic signed [AW-1:0] v);
		logic [AW-1:0] m;
		logic [AW-1:0] r;
		m = v[AW-1] ? AW'(-v) : AW'(v);
		r = (m + (AW'(1) << (NF - 1))) >> NF;
		return v[AW-1] ? -$signed(r[QW-1:0]) : $signed(r[QW-1:0]);
	endfunction

	function automatic logic signed [PRW-1:0] rnd_proj(input logic signed [PW-1:0] v);
		logic [PW-1:0] m;
		logic [PW-1:0] r;
		m = v[PW-1] ? PW'(-v) : PW'(v);
		r = (m + (PW'(1) << (NF - 1))) >> NF;
		return v[PW-1] ? -$signed(r[PRW-1:0]) : $signed(r[PRW-1:0]);
	endfunction

	function automatic logic signed [RTW-1:0] rnd_seg(input logic signed [TW-1:0] v);
		logic [TW-1:0] m;
		logic [TW-1:0] r;
		m = v[TW-1] ? TW'(-v) : TW'(v);
		r = (m + (TW'(1) << (TB - 1))) >> TB;
		return v[TW-1] ? -$signed(r[RTW-1:0]) : $signed(r[RTW-1:0]);
	endfunction

endpackage

@@ hw/rtl/stc_divider.sv @@
// Pipelined restoring divider: edge parameter t = num/den with one quotient bit per stage.
// Also classifies the segment clamp (first end, interior, second end).
// Depends on stc_pkg.
module stc_divider (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic signed [stc_pkg::NW-1:0] num,
	input  logic [stc_pkg::EW-1:0]        den,
	output logic                          out_valid,
	output stc_pkg::seg_t                 seg,
	output logic [stc_pkg::TB-1:0]        quo
);

	localparam int N  = stc_pkg::TB;
	localparam int EW = stc_pkg::EW;
	localparam int NW = stc_pkg::NW;

	logic [N:0]          vld_q;
	logic [EW-1:0]       rem_q [N+1];
	logic [EW-1:0]       den_q [N+1];
	logic [N-1:0]        quo_q [N+1];
	stc_pkg::seg_t       seg_q [N+1];
	logic [EW:0]         shl [N];
	logic [EW:0]         trial [N];
	logic [N-1:0]        qbit;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			shl[k]   = {rem_q[k], 1'b0};
			trial[k] = shl[k] - {1'b0, den_q[k]};
			qbit[k]  = (shl[k] >= {1'b0, den_q[k]});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		den_q[0] <= den;
		quo_q[0] <= '0;
		if (num[NW-1] || num == '0) begin
			seg_q[0] <= stc_pkg::SEG_FIRST;
			rem_q[0] <= '0;
		end else if (num[NW-1:0] >= NW'(den)) begin
			seg_q[0] <= stc_pkg::SEG_SECOND;
			rem_q[0] <= '0;
		end else begin
			seg_q[0] <= stc_pkg::SEG_MID;
			rem_q[0] <= num[EW-1:0];
		end
		for (int k = 0; k < N; k++) begin
			den_q[k+1] <= den_q[k];
			seg_q[k+1] <= seg_q[k];
			quo_q[k+1] <= {quo_q[k][N-2:0], qbit[k]};
			rem_q[k+1] <= qbit[k] ? trial[k][EW-1:0] : shl[k][EW-1:0];
		end
	end

	assign out_valid = vld_q[N];
	assign seg       = seg_q[N];
	assign quo       = quo_q[N];

endmodule

@@ hw/rtl/sphere_triangle_contact_top.sv @@
// Sphere-triangle contact: nearest triangle point to a sphere center and overlap class.
// Depends on stc_pkg and stc_divider.
//
// Usage:
//   Drive the sphere and triangle fields and pulse start; an item is taken at
//   every edge where start is high and busy is low. busy is always low, so a
//   new item may enter in every cycle.
//   One result per item is shown for one cycle with done high; items leave
//   in the order they entered.
//   Throughput is one item per cycle. Latency is set by the plane and edge
//   tests (10 stages), the edge-parameter divider (33 stages, one quotient
//   bit per stage for 32 fraction bits) and the clamp, select and distance
//   stages (5 stages).
//   The receiver cannot stall: results must be taken when done is high.
//   Reset clears all valid bits, so no result is shown until new items
//   arrive; items in flight at reset are dropped.
module sphere_triangle_contact_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  logic [stc_pkg::FW-1:0]    center,
	input  logic [stc_pkg::RADW-1:0]  sphere_radius,
	input  logic [stc_pkg::FW-1:0]    corner_a,
	input  logic [stc_pkg::FW-1:0]    corner_b,
	input  logic [stc_pkg::FW-1:0]    corner_c,
	input  logic [stc_pkg::FW-1:0]    unit_normal,
	output logic                      done,
	output logic [2:0]                contact_class,
	output logic [stc_pkg::FW-1:0]    nearest_point,
	output logic [stc_pkg::FW-1:0]    offset_vector,
	output logic [stc_pkg::OW-1:0]    distance_squared
);

	localparam int CB  = stc_pkg::CB;
	localparam int DW  = stc_pkg::DW;
	localparam int AW  = stc_pkg::AW;
	localparam int QW  = stc_pkg::QW;
	localparam int PW  = stc_pkg::PW;
	localparam int PRW = stc_pkg::PRW;
	localparam int XW  = stc_pkg::XW;
	localparam int SW  = stc_pkg::SW;
	localparam int NW  = stc_pkg::NW;
	localparam int EW  = stc_pkg::EW;
	localparam int TB  = stc_pkg::TB;
	localparam int TW  = stc_pkg::TW;
	localparam int RTW = stc_pkg::RTW;
	localparam int OW  = stc_pkg::OW;
	localparam int RW2 = 2 * stc_pkg::RADW;

	logic accept;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9, vld_s10;
	logic vld_s11, vld_s12, vld_s13, vld_s14, vld_s15;

	logic [stc_pkg::FW-1:0] in_corner [3];

	stc_pkg::base_t base_s1, base_s2, base_s3, base_s4, base_s5;
	stc_pkg::base_t base_s6, base_s7, base_s8, base_s9, base_s10;

	logic signed [DW-1:0]      cd_s1 [3][3];
	logic signed [DW-1:0]      e_s1 [3][3];
	logic signed [DW+CB-1:0]   pa_s2 [3];
	logic signed [2*DW-1:0]    nm_s2 [3][3];
	logic signed [2*DW-1:0]    dn_s2 [3][3];
	logic signed [QW-1:0]      aq_s3;
	logic signed [NW-1:0]      num_s3 [3], num_s4 [3], num_s5 [3], num_s6 [3], num_s7 [3],
	                           num_s8 [3], num_s9 [3], num_s10 [3];
	logic [EW-1:0]             den_s3 [3], den_s4 [3], den_s5 [3], den_s6 [3], den_s7 [3],
	                           den_s8 [3], den_s9 [3], den_s10 [3];
	logic signed [PW-1:0]      an_s4 [3];
	logic signed [CB-1:0]      proj_s5 [3];
	logic signed [CB-1:0]      proj_s6 [3];
	logic signed [CB-1:0]      proj_s7 [3];
	logic signed [CB-1:0]      proj_s8 [3];
	logic signed [CB-1:0]      proj_s9 [3];
	logic signed [CB-1:0]      proj_s10 [3];
	logic signed [DW-1:0]      p_s6 [3][3];
	logic signed [DW-1:0]      e_s6 [3][3];
	logic signed [2*DW-1:0]    pp_s7 [3][6];
	logic signed [XW-1:0]      x_s8 [3][3];
	logic signed [XW+CB-1:0]   xn_s9 [3][3];
	logic [2:0]                xnz_s9;
	logic [2:0]                on_s10, ed_s10;

	// plane and edge-test per-item combinational values
	logic signed [AW-1:0]      plane_sum;
	logic signed [NW-1:0]      num_sum [3];
	logic signed [NW-1:0]      den_sum [3];
	logic signed [PRW:0]       proj_diff [3];
	logic signed [SW-1:0]      xsum [3];

	// divider lanes and side line
	logic [2:0]                dvld;
	stc_pkg::seg_t             dseg [3];
	logic [TB-1:0]             dquo [3];
	stc_pkg::side_t            side_in;
	stc_pkg::side_t            side_q [TB+1];
	stc_pkg::side_t            sd;

	stc_pkg::side_t            side_s11, side_s12;
	logic signed [TW-1:0]      tb_s11 [3][3];
	stc_pkg::seg_t             seg_s11 [3];
	stc_pkg::seg_t             seg_s12 [3];
	logic signed [CB-1:0]      segpt_s12 [3][3];
	logic signed [DW-1:0]      bvec [3][3];
	logic signed [RTW:0]       mid_pt [3][3];

	logic [1:0]                on_cnt, ed_cnt, ei, jj, e1, e2;
	stc_pkg::cls_t             cls_n;
	logic signed [CB-1:0]      pt_n [3];

	stc_pkg::cls_t             cls_s13, cls_s14, cls_s15;
	logic signed [CB-1:0]      pt_s13 [3];
	logic signed [CB-1:0]      pt_s14 [3];
	logic [2:0][CB-1:0]        c_s13;
	logic [stc_pkg::RADW-1:0]  rad_s13;
	logic [RW2-1:0]            rad2_s14;
	logic signed [DW-1:0]      roff [3];
	logic signed [CB-1:0]      off_s14 [3];
	logic [2*DW-1:0]           sq_s14 [3];
	logic [NW-1:0]             dsum;
	logic [stc_pkg::FW-1:0]    pt_s15, off_s15;
	logic [OW-1:0]             dsq_s15;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign in_corner[0] = corner_a;
	assign in_corner[1] = corner_b;
	assign in_corner[2] = corner_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			vld_s4  <= 1'b0;
			vld_s5  <= 1'b0;
			vld_s6  <= 1'b0;
			vld_s7  <= 1'b0;
			vld_s8  <= 1'b0;
			vld_s9  <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
			vld_s13 <= 1'b0;
			vld_s14 <= 1'b0;
			vld_s15 <= 1'b0;
		end else begin
			vld_s1  <= accept;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			vld_s4  <= vld_s3;
			vld_s5  <= vld_s4;
			vld_s6  <= vld_s5;
			vld_s7  <= vld_s6;
			vld_s8  <= vld_s7;
			vld_s9  <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= &dvld;
			vld_s12 <= vld_s11;
			vld_s13 <= vld_s12;
			vld_s14 <= vld_s13;
			vld_s15 <= vld_s14;
		end
	end

	always_comb begin
		plane_sum = AW'(pa_s2[0]) + AW'(pa_s2[1]) + AW'(pa_s2[2]);
		for (int i = 0; i < 3; i++) begin
			num_sum[i] = NW'(nm_s2[i][0]) + NW'(nm_s2[i][1]) + NW'(nm_s2[i][2]);
			den_sum[i] = NW'(dn_s2[i][0]) + NW'(dn_s2[i][1]) + NW'(dn_s2[i][2]);
			proj_diff[i] = (PRW + 1)'($signed(base_s4.c[i]))
				- (PRW + 1)'(stc_pkg::rnd_proj(an_s4[i]));
			xsum[i] = SW'(xn_s9[i][0]) + SW'(xn_s9[i][1]) + SW'(xn_s9[i][2]);
		end
	end

	always_ff @(posedge clk) begin
		// s1: capture, corner differences
		for (int k = 0; k < 3; k++) begin
			base_s1.c[k] <= center[k*CB +: CB];
			base_s1.n[k] <= unit_normal[k*CB +: CB];
			for (int i = 0; i < 3; i++) begin
				base_s1.v[i][k] <= in_corner[i][k*CB +: CB];
				cd_s1[i][k] <= DW'($signed(center[k*CB +: CB]))
					- DW'($signed(in_corner[i][k*CB +: CB]));
				e_s1[i][k] <= DW'($signed(in_corner[(i == 2) ? 0 : i + 1][k*CB +: CB]))
					- DW'($signed(in_corner[i][k*CB +: CB]));
			end
		end
		base_s1.rad <= sphere_radius;

		// s2: products
		for (int k = 0; k < 3; k++) begin
			pa_s2[k] <= cd_s1[0][k] * $signed(base_s1.n[k]);
			for (int i = 0; i < 3; i++) begin
				nm_s2[i][k] <= cd_s1[i][k] * e_s1[i][k];
				dn_s2[i][k] <= e_s1[i][k] * e_s1[i][k];
			end
		end
		base_s2 <= base_s1;

		// s3: plane distance, segment numerators and denominators
		aq_s3   <= stc_pkg::rnd_plane(plane_sum);
		base_s3 <= base_s2;
		for (int i = 0; i < 3; i++) begin
			num_s3[i] <= num_sum[i];
			den_s3[i] <= den_sum[i][EW-1:0];
		end

		// s4: distance times normal
		for (int k = 0; k < 3; k++)
			an_s4[k] <= aq_s3 * $signed(base_s3.n[k]);
		base_s4 <= base_s3;
		num_s4  <= num_s3;
		den_s4  <= den_s3;

		// s5: projection
		for (int k = 0; k < 3; k++)
			proj_s5[k] <= stc_pkg::sat_coord(64'(proj_diff[k]));
		base_s5 <= base_s4;
		num_s5  <= num_s4;
		den_s5  <= den_s4;

		// s6: edge and point vectors
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				p_s6[i][k] <= DW'(proj_s5[k]) - DW'($signed(base_s5.v[i][k]));
				e_s6[i][k] <= DW'($signed(base_s5.v[(i == 2) ? 0 : i + 1][k]))
					- DW'($signed(base_s5.v[i][k]));
			end
		end
		proj_s6 <= proj_s5;
		base_s6 <= base_s5;
		num_s6  <= num_s5;
		den_s6  <= den_s5;

		// s7: cross product terms
		for (int i = 0; i < 3; i++) begin
			pp_s7[i][0] <= e_s6[i][1] * p_s6[i][2];
			pp_s7[i][1] <= e_s6[i][2] * p_s6[i][1];
			pp_s7[i][2] <= e_s6[i][2] * p_s6[i][0];
			pp_s7[i][3] <= e_s6[i][0] * p_s6[i][2];
			pp_s7[i][4] <= e_s6[i][0] * p_s6[i][1];
			pp_s7[i][5] <= e_s6[i][1] * p_s6[i][0];
		end
		proj_s7 <= proj_s6;
		base_s7 <= base_s6;
		num_s7  <= num_s6;
		den_s7  <= den_s6;

		// s8: cross products
		for (int i = 0; i < 3; i++) begin
			x_s8[i][0] <= XW'(pp_s7[i][0]) - XW'(pp_s7[i][1]);
			x_s8[i][1] <= XW'(pp_s7[i][2]) - XW'(pp_s7[i][3]);
			x_s8[i][2] <= XW'(pp_s7[i][4]) - XW'(pp_s7[i][5]);
		end
		proj_s8 <= proj_s7;
		base_s8 <= base_s7;
		num_s8  <= num_s7;
		den_s8  <= den_s7;

		// s9: cross dot normal terms
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				xn_s9[i][k] <= x_s8[i][k] * $signed(base_s8.n[k]);
			xnz_s9[i] <= (x_s8[i][0] != '0) || (x_s8[i][1] != '0) || (x_s8[i][2] != '0);
		end
		proj_s9 <= proj_s8;
		base_s9 <= base_s8;
		num_s9  <= num_s8;
		den_s9  <= den_s8;

		// s10: edge side tests
		for (int i = 0; i < 3; i++) begin
			on_s10[i] <= xnz_s9[i] && (xsum[i][SW-1] || xsum[i] == '0);
			ed_s10[i] <= xnz_s9[i] && (xsum[i] == '0);
		end
		proj_s10 <= proj_s9;
		base_s10 <= base_s9;
		num_s10  <= num_s9;
		den_s10  <= den_s9;
	end

	for (genvar g = 0; g < 3; g++) begin : g_div
		stc_divider u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (vld_s10),
			.num       (num_s10[g]),
			.den       (den_s10[g]),
			.out_valid (dvld[g]),
			.seg       (dseg[g]),
			.quo       (dquo[g])
		);
	end

	always_comb begin
		side_in.base     = base_s10;
		side_in.on       = on_s10;
		side_in.ed       = ed_s10;
		side_in.enclosed = ~|(on_s10 & ~ed_s10);
		for (int k = 0; k < 3; k++)
			side_in.proj[k] = proj_s10[k];
	end

	always_ff @(posedge clk) begin
		side_q[0] <= side_in;
		for (int k = 1; k <= TB; k++)
			side_q[k] <= side_q[k-1];
	end

	assign sd = side_q[TB];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				bvec[i][k] = DW'($signed(sd.base.v[(i == 2) ? 0 : i + 1][k]))
					- DW'($signed(sd.base.v[i][k]));
				mid_pt[i][k] = (RTW + 1)'($signed(side_s11.base.v[i][k]))
					+ (RTW + 1)'(stc_pkg::rnd_seg(tb_s11[i][k]));
			end
		end
	end

	always_ff @(posedge clk) begin
		// s11: t times edge vector
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++)
				tb_s11[i][k] <= $signed({1'b0, dquo[i]}) * bvec[i][k];
			seg_s11[i] <= dseg[i];
		end
		side_s11 <= sd;

		// s12: clamped point on each edge
		for (int i = 0; i < 3; i++) begin
			for (int k = 0; k < 3; k++) begin
				case (seg_s11[i])
					stc_pkg::SEG_MID:    segpt_s12[i][k] <= mid_pt[i][k][CB-1:0];
					stc_pkg::SEG_SECOND: segpt_s12[i][k] <=
						side_s11.base.v[(i == 2) ? 0 : i + 1][k];
					default:             segpt_s12[i][k] <= side_s11.base.v[i][k];
				endcase
			end
		end
		seg_s12  <= seg_s11;
		side_s12 <= side_s11;
	end

	// s13 select
	always_comb begin
		on_cnt = {1'b0, side_s12.on[0]} + {1'b0, side_s12.on[1]} + {1'b0, side_s12.on[2]};
		ed_cnt = {1'b0, side_s12.ed[0]} + {1'b0, side_s12.ed[1]} + {1'b0, side_s12.ed[2]};
		ei = side_s12.on[0] ? 2'd0 : (side_s12.on[1] ? 2'd1 : 2'd2);
		jj = !side_s12.on[0] ? 2'd0 : (!side_s12.on[1] ? 2'd1 : 2'd2);
		e1 = stc_pkg::next_edge(jj);
		e2 = stc_pkg::next_edge(e1);
		cls_n = stc_pkg::CLS_INTERIOR;
		for (int k = 0; k < 3; k++)
			pt_n[k] = side_s12.proj[k];
		if (side_s12.enclosed) begin
			if (ed_cnt == 2'd0)
				cls_n = stc_pkg::CLS_INTERIOR;
			else if (ed_cnt == 2'd1)
				cls_n = side_s12.ed[0] ? stc_pkg::CLS_EDGE_AB :
					(side_s12.ed[1] ? stc_pkg::CLS_EDGE_BC : stc_pkg::CLS_EDGE_CA);
			else
				cls_n = !side_s12.ed[0] ? stc_pkg::CLS_CORNER_C :
					(!side_s12.ed[1] ? stc_pkg::CLS_CORNER_A : stc_pkg::CLS_CORNER_B);
		end else if (on_cnt == 2'd1) begin
			for (int k = 0; k < 3; k++)
				pt_n[k] = segpt_s12[ei][k];
			if (seg_s12[ei] == stc_pkg::SEG_MID)
				cls_n = stc_pkg::CLS_EDGE_AB + stc_pkg::cls_t'(ei);
			else if (seg_s12[ei] == stc_pkg::SEG_FIRST)
				cls_n = stc_pkg::CLS_CORNER_A + stc_pkg::cls_t'(ei);
			else
				cls_n = stc_pkg::CLS_CORNER_A + stc_pkg::cls_t'(stc_pkg::next_edge(ei));
		end else if (seg_s12[e1] == stc_pkg::SEG_MID) begin
			for (int k = 0; k < 3; k++)
				pt_n[k] = segpt_s12[e1][k];
			cls_n = stc_pkg::CLS_EDGE_AB + stc_pkg::cls_t'(e1);
		end else if (seg_s12[e2] == stc_pkg::SEG_MID) begin
			for (int k = 0; k < 3; k++)
				pt_n[k] = segpt_s12[e2][k];
			cls_n = stc_pkg::CLS_EDGE_AB + stc_pkg::cls_t'(e2);
		end else begin
			for (int k = 0; k < 3; k++)
				pt_n[k] = side_s12.base.v[e2][k];
			cls_n = stc_pkg::CLS_CORNER_A + stc_pkg::cls_t'(e2);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			roff[k] = DW'($signed(c_s13[k])) - DW'(pt_s13[k]);
		dsum = NW'(sq_s14[0]) + NW'(sq_s14[1]) + NW'(sq_s14[2]);
	end

	always_ff @(posedge clk) begin
		// s13
		cls_s13 <= cls_n;
		pt_s13  <= pt_n;
		c_s13   <= side_s12.base.c;
		rad_s13 <= side_s12.base.rad;

		// s14: offset and squares
		for (int k = 0; k < 3; k++) begin
			off_s14[k] <= stc_pkg::sat_coord(64'(roff[k]));
			sq_s14[k]  <= roff[k] * roff[k];
		end
		rad2_s14 <= rad_s13 * rad_s13;
		cls_s14  <= cls_s13;
		pt_s14   <= pt_s13;

		// s15: distance, overlap test
		cls_s15 <= (dsum < NW'(rad2_s14)) ? cls_s14 : stc_pkg::CLS_NONE;
		dsq_s15 <= (dsum > NW'({OW{1'b1}})) ? {OW{1'b1}} : dsum[OW-1:0];
		pt_s15  <= {pt_s14[2], pt_s14[1], pt_s14[0]};
		off_s15 <= {off_s14[2], off_s14[1], off_s14[0]};
	end

	assign done             = vld_s15;
	assign contact_class    = cls_s15;
	assign nearest_point    = pt_s15;
	assign offset_vector    = off_s15;
	assign distance_squared = dsq_s15;

endmodule
